### rtl/hcbd_pkg.sv
// Shared types and constants for the HTTP chunked body decoder.
package hcbd_pkg;

  // Width of the chunk size and byte counters
  localparam int SIZE_BITS = 32;

  // Configuration port geometry
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  // Register indexes (byte address is four times the index)
  localparam logic REG_CHUNKED_MODE = 1'b0;
  localparam logic REG_BODY_LENGTH  = 1'b1;

  // Framing characters
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  // Configuration seen by the decoder
  typedef struct packed {
    logic        chunked_mode;
    logic [31:0] body_length;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic       byte_consumed;
    logic       body_complete;
    logic       error_code;
  } res_t;

endpackage

### rtl/http_chunked_body_decoder.sv
// Top level of the HTTP chunked body decoder.
// The result for an accepted byte is registered in the result buffer before it is shown.
// Throughput: one byte per cycle while in_stall is low; the framing update and the size
// shift-add are combinational, and a two-entry result buffer keeps input flowing.
// in_stall is high only while both result entries are occupied.
// Reset (rst, synchronous): clears framing state, counters, flags, registers.
module http_chunked_body_decoder import hcbd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        data_byte,
  input  logic              start_new_body,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        payload_byte,
  output logic              payload_valid,
  output logic              byte_consumed,
  output logic              body_complete,
  output logic              error_code
);

  cfg_t cfg;
  res_t res;
  res_t head;
  logic accept;
  logic full;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  hcbd_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  hcbd_frame u_frame (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .accept         (accept),
    .data_byte      (data_byte),
    .start_new_body (start_new_body),
    .res            (res)
  );

  hcbd_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .res       (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  // Drive the result ports from the buffer head
  assign payload_byte  = head.payload_byte;
  assign payload_valid = head.payload_valid;
  assign byte_consumed = head.byte_consumed;
  assign body_complete = head.body_complete;
  assign error_code    = head.error_code;

endmodule

### rtl/hcbd_apb_regs.sv
// APB-style configuration registers for the body decoder.
module hcbd_apb_regs import hcbd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic reg_index;
  logic wr_en;

  // Decode the word index from the byte address
  assign reg_index = paddr[2];
  assign wr_en     = psel && penable && pwrite;
  assign pready    = 1'b1;

  // Write the addressed register
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.chunked_mode <= 1'b0;
      cfg.body_length  <= '0;
    end else if (wr_en) begin
      case (reg_index)
        REG_CHUNKED_MODE: cfg.chunked_mode <= pwdata[0];
        REG_BODY_LENGTH:  cfg.body_length  <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  // Return the addressed register
  always_comb begin
    case (reg_index)
      REG_CHUNKED_MODE: prdata = {{(DATA_W-1){1'b0}}, cfg.chunked_mode};
      REG_BODY_LENGTH:  prdata = cfg.body_length;
      default:          prdata = '0;
    endcase
  end

endmodule

### rtl/hcbd_frame.sv
// Framing state machine and counters: one byte handled per accepted request.
module hcbd_frame import hcbd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       start_new_body,
  output res_t       res
);

  typedef enum logic [8:0] {
    ST_START     = 9'b000000001,
    ST_SIZE      = 9'b000000010,
    ST_SIZE_LF   = 9'b000000100,
    ST_DATA      = 9'b000001000,
    ST_AFTER     = 9'b000010000,
    ST_AFTER_LF  = 9'b000100000,
    ST_LAST_LF   = 9'b001000000,
    ST_LAST_LINE = 9'b010000000,
    ST_END_LF    = 9'b100000000
  } frame_state_t;

  frame_state_t         framing_state, framing_state_next, cur_state;
  logic [SIZE_BITS-1:0] chunk_length, chunk_length_next, cur_chunk;
  logic [SIZE_BITS-1:0] bytes_counted, bytes_counted_next, cur_count;
  logic [SIZE_BITS-1:0] count_inc;
  logic                 done_flag, done_flag_next, cur_done;
  logic                 error_flag, error_flag_next, cur_error;
  logic                 payload, consumed;
  logic                 is_hex;
  logic [3:0]           hex_val;
  logic [7:0]           low_byte;
  logic [SIZE_BITS-1:0] body_len_ext;

  // Decode a case-insensitive hex digit
  always_comb begin
    low_byte = data_byte | 8'h20;
    is_hex   = 1'b0;
    hex_val  = 4'd0;
    if (data_byte >= 8'h30 && data_byte <= 8'h39) begin
      is_hex  = 1'b1;
      hex_val = data_byte[3:0];
    end else if (low_byte >= 8'h61 && low_byte <= 8'h66) begin
      is_hex  = 1'b1;
      hex_val = low_byte[3:0] + 4'd9;
    end
  end

  // Start from cleared state when a new body begins
  always_comb begin
    if (start_new_body) begin
      cur_state = ST_START;
      cur_chunk = '0;
      cur_count = '0;
      cur_done  = 1'b0;
      cur_error = 1'b0;
    end else begin
      cur_state = framing_state;
      cur_chunk = chunk_length;
      cur_count = bytes_counted;
      cur_done  = done_flag;
      cur_error = error_flag;
    end
  end

  assign count_inc    = cur_count + 1'b1;
  assign body_len_ext = SIZE_BITS'(cfg.body_length);

  // Work out the next state and the result for this byte
  always_comb begin
    framing_state_next = cur_state;
    chunk_length_next  = cur_chunk;
    bytes_counted_next = cur_count;
    done_flag_next     = cur_done;
    error_flag_next    = cur_error;
    payload            = 1'b0;
    consumed           = 1'b0;
    if (!cur_done && !cur_error) begin
      if (cfg.chunked_mode) begin
        consumed = 1'b1;
        case (cur_state)
          ST_START: begin
            if (!is_hex) begin
              error_flag_next = 1'b1;
            end else begin
              chunk_length_next  = SIZE_BITS'(hex_val);
              framing_state_next = ST_SIZE;
            end
          end
          ST_SIZE: begin
            // Refuse any byte once another digit would overflow
            if (cur_chunk[SIZE_BITS-1 -: 4] != 4'd0) begin
              error_flag_next = 1'b1;
            end else if (is_hex) begin
              chunk_length_next = {cur_chunk[SIZE_BITS-5:0], hex_val};
            end else if (data_byte == CH_CR) begin
              framing_state_next = (cur_chunk == '0) ? ST_LAST_LF : ST_SIZE_LF;
            end else if (data_byte == CH_LF) begin
              framing_state_next = (cur_chunk == '0) ? ST_LAST_LINE : ST_DATA;
            end else begin
              error_flag_next = 1'b1;
            end
          end
          ST_SIZE_LF: begin
            if (data_byte == CH_LF) framing_state_next = ST_DATA;
            else error_flag_next = 1'b1;
          end
          ST_DATA: begin
            payload            = 1'b1;
            bytes_counted_next = count_inc;
            if (count_inc == cur_chunk) begin
              framing_state_next = ST_AFTER;
              chunk_length_next  = '0;
              bytes_counted_next = '0;
            end
          end
          ST_AFTER: begin
            if (data_byte == CH_CR) framing_state_next = ST_AFTER_LF;
            else if (data_byte == CH_LF) framing_state_next = ST_START;
            else error_flag_next = 1'b1;
          end
          ST_AFTER_LF: begin
            if (data_byte == CH_LF) framing_state_next = ST_START;
            else error_flag_next = 1'b1;
          end
          ST_LAST_LF: begin
            if (data_byte == CH_LF) framing_state_next = ST_LAST_LINE;
            else error_flag_next = 1'b1;
          end
          ST_LAST_LINE: begin
            if (data_byte == CH_CR) framing_state_next = ST_END_LF;
            else if (data_byte == CH_LF) done_flag_next = 1'b1;
            else error_flag_next = 1'b1;
          end
          ST_END_LF: begin
            if (data_byte == CH_LF) done_flag_next = 1'b1;
            else error_flag_next = 1'b1;
          end
          default: error_flag_next = 1'b1;
        endcase
      end else if (cur_count > body_len_ext) begin
        error_flag_next = 1'b1;
      end else if (cur_count == body_len_ext) begin
        done_flag_next = 1'b1;
      end else begin
        // Length mode: pass the byte and count it
        consumed           = 1'b1;
        payload            = 1'b1;
        bytes_counted_next = count_inc;
        if (count_inc == body_len_ext) done_flag_next = 1'b1;
      end
    end
  end

  // Build the result for this byte
  always_comb begin
    res.payload_byte  = payload ? data_byte : 8'd0;
    res.payload_valid = payload;
    res.byte_consumed = consumed;
    res.body_complete = done_flag_next;
    res.error_code    = error_flag_next;
  end

  // Advance the state on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      framing_state <= ST_START;
      chunk_length  <= '0;
      bytes_counted <= '0;
      done_flag     <= 1'b0;
      error_flag    <= 1'b0;
    end else if (accept) begin
      framing_state <= framing_state_next;
      chunk_length  <= chunk_length_next;
      bytes_counted <= bytes_counted_next;
      done_flag     <= done_flag_next;
      error_flag    <= error_flag_next;
    end
  end

  // A finished or failed body refuses further bytes
  a_refuse_after_end: assert property (@(posedge clk) disable iff (rst)
    accept && !start_new_body && (done_flag || error_flag) |-> !res.byte_consumed)
    else $error("byte consumed after body end");

  // Payload is always a consumed byte and never raises the error
  a_payload_clean: assert property (@(posedge clk) disable iff (rst)
    accept && res.payload_valid |-> res.byte_consumed && !res.error_code)
    else $error("payload byte flagged inconsistently");

  // The error stays until a new body begins
  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    error_flag && !(accept && start_new_body) |=> error_flag)
    else $error("error flag dropped");

endmodule

### rtl/hcbd_out_buf.sv
// Two-entry result buffer that decouples the input side from output stalls.
module hcbd_out_buf import hcbd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  res_t res,
  output logic full,
  output logic out_valid,
  input  logic out_stall,
  output res_t head
);

  logic [1:0] count;
  res_t       tail;
  logic       pop;

  assign pop       = out_valid && !out_stall;
  assign out_valid = (count != 2'd0);
  assign full      = (count == 2'd2);

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Hold results in order: head is shown, tail waits behind it
  always_ff @(posedge clk) begin
    if (count == 2'd2) begin
      if (pop) head <= tail;
    end else if (count == 2'd1) begin
      if (push && pop) head <= res;
      else if (push) tail <= res;
    end else begin
      if (push) head <= res;
    end
  end

  // Occupancy never passes two
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("result buffer overflow");

  // A full, stalled buffer holds its head
  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    full && out_stall |=> full && $stable(head))
    else $error("stalled head changed");

  // A request pushed behind a stalled result fills the buffer
  a_fill: assert property (@(posedge clk) disable iff (rst)
    count == 2'd1 && push && !pop |=> full)
    else $error("buffer did not fill");

endmodule
